[hw/rtl/frustum_cull_test_assert.svh]
// Assertion macros shared by the frustum cull test RTL.
`ifndef FRUSTUM_CULL_TEST_ASSERT_SVH
`define FRUSTUM_CULL_TEST_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define FCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fct_pkg.sv]
// Types, constants and helpers for the frustum cull test block.
package fct_pkg;

    localparam int COORD_W = 32;
    localparam int EXT_W   = 31;
    localparam int IDX_W   = 3;
    localparam int KIND_W  = 2;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int ABS_W   = COORD_W + 2;
    localparam int MAG_W   = EXT_W + ABS_W;

    // Item kinds carried on tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_POINT  = 2'd1,
        KIND_SPHERE = 2'd2,
        KIND_CUBE   = 2'd3
    } kind_t;

    // One clip plane: normal (a, b, c) and offset d, all signed Q format
    typedef struct packed {
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] d;
    } plane_t;

    // Query attributes that travel beside the datapath
    typedef struct packed {
        kind_t              kind;
        logic [EXT_W-1:0]   extent;
    } query_meta_t;

    // Load enables of the three lane stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // Magnitude of a signed coordinate; the most negative value maps to 2^31
    function automatic logic [COORD_W-1:0] abs_coord(input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W-1:0] neg;
        neg = -v;
        return v[COORD_W-1] ? COORD_W'(neg) : COORD_W'(v);
    endfunction

endpackage

[hw/rtl/frustum_cull_test.sv]
// Top level of the six-plane frustum cull test: plane store, lanes and handshake.
//
// Channel   Dir  tdata (low bit up)                                  tuser
// s_        in   plane_index, plane_a..d, pos_x..z, extent, pad       kind
// m_        out  inside_res, pad                                      -
//
// One item per cycle unless m_ stalls; a query passes the input register, the
// three lane stages and the output register before m_tvalid rises.
// Each lane computes by multiply, two adder levels, final add and compare.
// Plane writes update the store at their transfer and give no result.
// Reset clears all planes and pipeline valids.
// Stalls on m_ ripple back stage by stage; bubbles are squeezed out first.
module frustum_cull_test #(
    parameter int PLANE_COUNT = 6,
    parameter int FRAC_BITS   = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // plane_index, plane_a, plane_b, plane_c, plane_d, pos_x, pos_y, pos_z, extent
    input  logic [263:0]  s_tdata,
    // kind
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // inside_res
    output logic [7:0]    m_tdata
);
    import fct_pkg::*;

    localparam int IDX_LSB = 0;
    localparam int A_LSB   = IDX_LSB + IDX_W;
    localparam int B_LSB   = A_LSB + COORD_W;
    localparam int C_LSB   = B_LSB + COORD_W;
    localparam int D_LSB   = C_LSB + COORD_W;
    localparam int X_LSB   = D_LSB + COORD_W;
    localparam int Y_LSB   = X_LSB + COORD_W;
    localparam int Z_LSB   = Y_LSB + COORD_W;
    localparam int E_LSB   = Z_LSB + COORD_W;

    // Input field unpack
    kind_t       in_kind;
    plane_t      in_plane;
    query_meta_t in_meta;
    logic        s_xfer;

    assign in_kind    = kind_t'(s_tuser);
    assign in_plane.a = $signed(s_tdata[A_LSB +: COORD_W]);
    assign in_plane.b = $signed(s_tdata[B_LSB +: COORD_W]);
    assign in_plane.c = $signed(s_tdata[C_LSB +: COORD_W]);
    assign in_plane.d = $signed(s_tdata[D_LSB +: COORD_W]);
    assign in_meta.kind   = in_kind;
    assign in_meta.extent = s_tdata[E_LSB +: EXT_W];
    assign s_xfer = s_tvalid && s_tready;

    // Plane store
    plane_t planes [PLANE_COUNT];
    logic   wr_en;

    assign wr_en = s_xfer && (in_kind == KIND_WRITE);

    fct_plane_store #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_idx   (s_tdata[IDX_LSB +: IDX_W]),
        .wr_plane (in_plane),
        .planes_o (planes)
    );

    // Stage ready chain, each stage loads when empty or draining
    logic v0_reg, v1_reg, v2_reg, v3_reg, vout_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy_out;
    stage_en_t en;

    assign rdy_out  = !vout_reg || m_tready;
    assign rdy3     = !v3_reg || rdy_out;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign s_tready = rdy0;
    assign en.s1    = rdy1;
    assign en.s2    = rdy2;
    assign en.s3    = rdy3;

    // Valid bits; plane writes do not enter the pipeline
    logic v0_next;
    assign v0_next = s_tvalid && (in_kind != KIND_WRITE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end else begin
            if (rdy0)    v0_reg   <= v0_next;
            if (rdy1)    v1_reg   <= v0_reg;
            if (rdy2)    v2_reg   <= v1_reg;
            if (rdy3)    v3_reg   <= v2_reg;
            if (rdy_out) vout_reg <= v3_reg;
        end
    end

    // Query payload: position at stage 0, kind and extent through stage 2
    logic signed [COORD_W-1:0] x0_reg, y0_reg, z0_reg;
    query_meta_t meta0_reg, meta1_reg, meta2_reg;

    always_ff @(posedge aclk) begin
        if (rdy0) begin
            x0_reg    <= $signed(s_tdata[X_LSB +: COORD_W]);
            y0_reg    <= $signed(s_tdata[Y_LSB +: COORD_W]);
            z0_reg    <= $signed(s_tdata[Z_LSB +: COORD_W]);
            meta0_reg <= in_meta;
        end
        if (rdy1) meta1_reg <= meta0_reg;
        if (rdy2) meta2_reg <= meta1_reg;
    end

    // One lane per plane
    logic [PLANE_COUNT-1:0] pass;

    for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
        fct_plane_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk   (aclk),
            .en     (en),
            .plane  (planes[i]),
            .pos_x  (x0_reg),
            .pos_y  (y0_reg),
            .pos_z  (z0_reg),
            .meta1  (meta1_reg),
            .meta2  (meta2_reg),
            .pass_o (pass[i])
        );
    end

    // Output register
    logic inside_reg, inside_next;
    assign inside_next = &pass;

    always_ff @(posedge aclk) begin
        if (rdy_out) begin
            inside_reg <= inside_next;
        end
    end

    assign m_tvalid = vout_reg;
    assign m_tdata  = {7'b0, inside_reg};

`include "frustum_cull_test_assert.svh"

    `FCT_ASSERT(a_stall_full, (!s_tready |-> (v0_reg && v1_reg && v2_reg && v3_reg && vout_reg)), "input stalled with a bubble in the pipeline")
    `FCT_ASSERT(a_out_source, ($rose(m_tvalid) |-> $past(v3_reg)), "result appeared without a query in the last lane stage")
    `FCT_ASSERT_NEXT(a_store_write, (wr_en && (s_tdata[IDX_LSB +: IDX_W] == IDX_W'(0))), (planes[0] == $past(in_plane)), "plane write did not reach the store")

endmodule

[hw/rtl/fct_plane_store.sv]
// Register file of clip planes, cleared by reset, written one plane per transfer.
module fct_plane_store #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [fct_pkg::IDX_W-1:0]   wr_idx,
    input  fct_pkg::plane_t             wr_plane,
    output fct_pkg::plane_t             planes_o [PLANE_COUNT]
);
    import fct_pkg::*;

    plane_t plane_reg  [PLANE_COUNT];
    plane_t plane_next [PLANE_COUNT];

    // Index past the last plane matches no entry and is dropped
    always_comb begin
        for (int i = 0; i < PLANE_COUNT; i++) begin
            plane_next[i] = plane_reg[i];
            if (wr_en && (wr_idx == IDX_W'(i))) begin
                plane_next[i] = wr_plane;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < PLANE_COUNT; i++) begin
            if (!aresetn) begin
                plane_reg[i] <= '0;
            end else begin
                plane_reg[i] <= plane_next[i];
            end
        end
    end

    assign planes_o = plane_reg;

endmodule

[hw/rtl/fct_plane_lane.sv]
// Pipelined signed-distance test of one query against one clip plane.
module fct_plane_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  fct_pkg::stage_en_t                  en,
    input  fct_pkg::plane_t                     plane,
    input  logic signed [fct_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [fct_pkg::COORD_W-1:0]  pos_y,
    input  logic signed [fct_pkg::COORD_W-1:0]  pos_z,
    input  fct_pkg::query_meta_t                meta1,
    input  fct_pkg::query_meta_t                meta2,
    output logic                                pass_o
);
    import fct_pkg::*;

    // Wide enough for three products, the shifted offset and the extent bias
    localparam int BASE_W = ((COORD_W + FRAC_BITS) > (MAG_W + 1)) ?
                            (COORD_W + FRAC_BITS) : (MAG_W + 1);
    localparam int SUM_W  = BASE_W + 3;

    // Stage 1: products with the stored plane, normal magnitude sum
    logic signed [PROD_W-1:0]  ax_reg, by_reg, cz_reg;
    logic signed [PROD_W-1:0]  ax_next, by_next, cz_next;
    logic signed [COORD_W-1:0] d_reg;
    logic [ABS_W-1:0]          abs_reg, abs_next;

    always_comb begin
        ax_next  = PROD_W'(plane.a) * PROD_W'(pos_x);
        by_next  = PROD_W'(plane.b) * PROD_W'(pos_y);
        cz_next  = PROD_W'(plane.c) * PROD_W'(pos_z);
        abs_next = ABS_W'(abs_coord(plane.a)) + ABS_W'(abs_coord(plane.b))
                 + ABS_W'(abs_coord(plane.c));
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            ax_reg  <= ax_next;
            by_reg  <= by_next;
            cz_reg  <= cz_next;
            d_reg   <= plane.d;
            abs_reg <= abs_next;
        end
    end

    // Stage 2: pairwise sums and the cube corner reach e * (|a|+|b|+|c|)
    logic signed [SUM_W-1:0] p_reg, q_reg, p_next, q_next;
    logic [MAG_W-1:0]        m_reg, m_next;

    always_comb begin
        p_next = SUM_W'(ax_reg) + SUM_W'(by_reg);
        q_next = SUM_W'(cz_reg) + (SUM_W'(d_reg) <<< FRAC_BITS);
        m_next = MAG_W'(meta1.extent) * MAG_W'(abs_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            p_reg <= p_next;
            q_reg <= q_next;
            m_reg <= m_next;
        end
    end

    // Stage 3: center distance and the shape bias
    logic signed [SUM_W-1:0] dist_reg, bias_reg, dist_next, bias_next;

    always_comb begin
        dist_next = p_reg + q_reg;
        unique case (meta2.kind)
            KIND_SPHERE: bias_next = $signed(SUM_W'(meta2.extent) << FRAC_BITS);
            KIND_CUBE:   bias_next = $signed(SUM_W'(m_reg));
            default:     bias_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            dist_reg <= dist_next;
            bias_reg <= bias_next;
        end
    end

    // Point, best corner or sphere rim must lie strictly on the inner side
    logic signed [SUM_W-1:0] total;
    assign total  = dist_reg + bias_reg;
    assign pass_o = (total > $signed(SUM_W'(0)));

endmodule
